FILE: rtl/qrmd_pkg.sv
// shared types, constants and the carrier reference table for the demodulator
package qrmd_pkg;

  // reference carrier period held by the table
  localparam int CARRIER_TABLE_LEN = 18;
  localparam int TABLE_IDX_W       = 5;
  localparam int SAMPLE_W          = 32;
  localparam int TOL_W             = 17;
  localparam int QDEPTH            = 4;
  localparam int QPTR_W            = 2;
  localparam int QCNT_W            = 3;

  typedef enum logic [1:0] {
    KIND_DIBIT = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_START = 3'd1,
    ERR_SYNC      = 3'd2,
    ERR_NO_PHASE  = 3'd3,
    ERR_LENGTH    = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    ST_FIRST  = 3'd0,
    ST_RUN    = 3'd1,
    ST_SYNC   = 3'd2,
    ST_DATA   = 3'd3,
    ST_FAILED = 3'd4
  } stage_t;

  typedef struct packed {
    kind_t      kind;
    logic [1:0] dibit;
    err_t       code;
  } res_t;

  // up to two results produced by one item, in stream order
  typedef struct packed {
    logic [1:0] cnt;
    res_t       res0;
    res_t       res1;
  } push_t;

  typedef logic [CARRIER_TABLE_LEN-1:0][3:0][SAMPLE_W-1:0] ref_table_t;

  // peak amplitude times sine of 5, 15, ..., 85 degrees, truncated
  function automatic logic [SAMPLE_W-1:0] sine_mag(input int k);
    logic [SAMPLE_W-1:0] m;
    case (k)
      0: m = 32'd185703301;
      1: m = 32'd551467404;
      2: m = 32'd900475448;
      3: m = 32'd1222123002;
      4: m = 32'd1506636966;
      5: m = 32'd1745372529;
      6: m = 32'd1931075831;
      7: m = 32'd2058104370;
      8: m = 32'd2122598450;
      default: m = '0;
    endcase
    return m;
  endfunction

  // normal-order candidate phases in degrees
  function automatic int phase_deg(input int p);
    int d;
    case (p)
      0: d = 135;
      1: d = 45;
      2: d = 225;
      3: d = 315;
      default: d = 0;
    endcase
    return d;
  endfunction

  // one carrier period for the four normal-order phases, built at elaboration
  function automatic ref_table_t build_ref_table();
    ref_table_t t;
    int deg;
    int r;
    int k;
    logic [SAMPLE_W-1:0] mag;
    for (int ph = 0; ph < CARRIER_TABLE_LEN; ph++) begin
      for (int p = 0; p < 4; p++) begin
        deg = 20 * ph + phase_deg(p);
        if (deg >= 360) begin
          deg = deg - 360;
        end
        r = (deg >= 180) ? deg - 180 : deg;
        k = (r < 90) ? (r - 5) / 10 : (175 - r) / 10;
        mag = sine_mag(k);
        t[ph][p] = (deg >= 180) ? (~mag + 32'd1) : mag;
      end
    end
    return t;
  endfunction

  localparam ref_table_t REF_TABLE = build_ref_table();

endpackage

FILE: rtl/qrmd_match.sv
// tolerance compare of one sample against the four normal-order reference carriers
module qrmd_match
  import qrmd_pkg::*;
(
  input  logic [SAMPLE_W-1:0]    sample,
  input  logic [TABLE_IDX_W-1:0] table_index,
  input  logic [TOL_W-1:0]       tolerance,
  output logic [3:0]             raw_match
);

  // exact 33-bit difference, magnitude, compare against tolerance
  always_comb begin
    logic signed [SAMPLE_W:0] diff;
    logic [SAMPLE_W:0]        mag;
    logic [SAMPLE_W-1:0]      ref_val;
    for (int c = 0; c < 4; c++) begin
      ref_val = REF_TABLE[table_index][c];
      diff = $signed({ref_val[SAMPLE_W-1], ref_val}) - $signed({sample[SAMPLE_W-1], sample});
      mag = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
      raw_match[c] = (mag <= {{(SAMPLE_W + 1 - TOL_W){1'b0}}, tolerance});
    end
  end

endmodule

FILE: rtl/qrmd_fsm.sv
// decode state: phase order, symbol timing, candidate masks and result generation
module qrmd_fsm
  import qrmd_pkg::*;
#(
  parameter int CARRIER_PERIOD = 18,
  parameter int MAX_SYMBOL_LEN = 4096,
  parameter int SYNC_SYMBOLS   = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic                   last,
  input  logic [3:0]             raw_match,
  output logic [TABLE_IDX_W-1:0] table_index,
  output push_t                  push
);

  localparam int IW = (CARRIER_PERIOD > 1) ? $clog2(CARRIER_PERIOD) : 1;
  localparam int LW = $clog2(MAX_SYMBOL_LEN + 1);
  localparam int SW = $clog2(SYNC_SYMBOLS + 1);

  stage_t                   stage, stage_next, stage_mid;
  logic                     mirrored_order, mirrored_order_next;
  logic [IW-1:0]            carrier_index, carrier_index_next;
  logic [TABLE_IDX_W-1:0]   table_index_next;
  logic [LW-1:0]            symbol_length, symbol_length_next;
  logic [LW-1:0]            position_in_symbol, position_in_symbol_next, pos_mid;
  logic [3:0]               candidate_mask, candidate_mask_next;
  logic [SW-1:0]            sync_symbols_seen, sync_symbols_seen_next;

  logic [3:0]               m;
  logic                     sym_active;
  logic [3:0]               mask_new;
  logic [LW-1:0]            pos_base;
  logic [SW-1:0]            seen_base;
  stage_t                   sym_stage;
  logic                     sym_end;
  logic [1:0]               low_cand;
  logic                     sync_ok;
  logic                     run_too_long;

  // candidates in the current phase order
  assign m = mirrored_order ? {raw_match[1], raw_match[0], raw_match[3], raw_match[2]}
                            : raw_match;

  // symbol-sample decode shared by next state and results
  always_comb begin
    logic [LW:0] pos_inc;
    sym_active = (stage == ST_SYNC) || (stage == ST_DATA) || ((stage == ST_RUN) && !m[0]);
    mask_new   = ((stage == ST_RUN) ? 4'hF : candidate_mask) & m;
    pos_base   = (stage == ST_RUN) ? '0 : position_in_symbol;
    seen_base  = (stage == ST_RUN) ? SW'(1) : sync_symbols_seen;
    if (stage == ST_RUN) begin
      sym_stage = (SYNC_SYMBOLS <= 1) ? ST_DATA : ST_SYNC;
    end else begin
      sym_stage = stage;
    end
    pos_inc = {1'b0, pos_base} + 1'b1;
    sym_end = (pos_inc >= {1'b0, symbol_length});
    if (mask_new[0]) begin
      low_cand = 2'd0;
    end else if (mask_new[1]) begin
      low_cand = 2'd1;
    end else if (mask_new[2]) begin
      low_cand = 2'd2;
    end else begin
      low_cand = 2'd3;
    end
    sync_ok      = (low_cand == (seen_base[0] ? 2'd3 : 2'd0));
    run_too_long = (symbol_length >= LW'(MAX_SYMBOL_LEN));
  end

  // next state
  always_comb begin
    stage_mid               = stage;
    mirrored_order_next     = mirrored_order;
    symbol_length_next      = symbol_length;
    position_in_symbol_next = position_in_symbol;
    candidate_mask_next     = candidate_mask;
    sync_symbols_seen_next  = sync_symbols_seen;

    // carrier counters advance on every item
    if ({1'b0, carrier_index} + 1'b1 >= (IW + 1)'(CARRIER_PERIOD)) begin
      carrier_index_next = '0;
      table_index_next   = '0;
    end else begin
      carrier_index_next = carrier_index + 1'b1;
      table_index_next   = (table_index == TABLE_IDX_W'(CARRIER_TABLE_LEN - 1)) ? '0
                                                                   : table_index + 1'b1;
    end

    case (stage)
      ST_FIRST: begin
        if (raw_match[0]) begin
          mirrored_order_next = 1'b0;
          stage_mid           = ST_RUN;
          symbol_length_next  = LW'(1);
        end else if (raw_match[2]) begin
          mirrored_order_next = 1'b1;
          stage_mid           = ST_RUN;
          symbol_length_next  = LW'(1);
        end else begin
          mirrored_order_next = 1'b0;
          stage_mid           = ST_FAILED;
        end
      end
      ST_RUN, ST_SYNC, ST_DATA: begin
        if (!sym_active) begin
          // still inside the first symbol run
          if (run_too_long) begin
            stage_mid = ST_FAILED;
          end else begin
            symbol_length_next = symbol_length + 1'b1;
          end
        end else begin
          sync_symbols_seen_next = seen_base;
          stage_mid              = sym_stage;
          if (!sym_end) begin
            position_in_symbol_next = pos_base + 1'b1;
            candidate_mask_next     = mask_new;
          end else begin
            position_in_symbol_next = '0;
            if (mask_new == 4'h0) begin
              candidate_mask_next = mask_new;
              stage_mid           = ST_FAILED;
            end else begin
              candidate_mask_next = 4'hF;
              if (sym_stage == ST_SYNC) begin
                if (!sync_ok) begin
                  stage_mid = ST_FAILED;
                end else begin
                  sync_symbols_seen_next = seen_base + 1'b1;
                  if (seen_base + 1'b1 >= SW'(SYNC_SYMBOLS)) begin
                    stage_mid = ST_DATA;
                  end
                end
              end
            end
          end
        end
      end
      default: begin
      end
    endcase

    pos_mid    = position_in_symbol_next;
    stage_next = stage_mid;

    // end of stream returns to the start state
    if (last) begin
      stage_next              = ST_FIRST;
      mirrored_order_next     = 1'b0;
      carrier_index_next      = '0;
      table_index_next        = '0;
      symbol_length_next      = '0;
      position_in_symbol_next = '0;
      candidate_mask_next     = 4'hF;
      sync_symbols_seen_next  = '0;
    end
  end

  // results for this item
  always_comb begin
    logic emit0;
    logic emit1;
    res_t first_res;
    res_t end_res;
    emit0     = 1'b0;
    first_res = '{kind: KIND_ERROR, dibit: 2'd0, code: ERR_NONE};
    case (stage)
      ST_FIRST: begin
        if (!raw_match[0] && !raw_match[2]) begin
          emit0          = 1'b1;
          first_res.code = ERR_BAD_START;
        end
      end
      ST_RUN, ST_SYNC, ST_DATA: begin
        if (!sym_active) begin
          if (run_too_long) begin
            emit0          = 1'b1;
            first_res.code = ERR_LENGTH;
          end
        end else if (sym_end) begin
          if (mask_new == 4'h0) begin
            emit0          = 1'b1;
            first_res.code = ERR_NO_PHASE;
          end else if (sym_stage == ST_SYNC) begin
            if (!sync_ok) begin
              emit0          = 1'b1;
              first_res.code = ERR_SYNC;
            end
          end else begin
            emit0     = 1'b1;
            first_res = '{kind: KIND_DIBIT, dibit: low_cand, code: ERR_NONE};
          end
        end
      end
      default: begin
      end
    endcase

    emit1 = last && (stage_mid != ST_FAILED);
    if ((stage_mid == ST_DATA) && (pos_mid == '0)) begin
      end_res = '{kind: KIND_END, dibit: 2'd0, code: ERR_NONE};
    end else begin
      end_res = '{kind: KIND_ERROR, dibit: 2'd0, code: ERR_LENGTH};
    end

    push.res0 = emit0 ? first_res : end_res;
    push.res1 = end_res;
    if (!step) begin
      push.cnt = 2'd0;
    end else begin
      push.cnt = {1'b0, emit0} + {1'b0, emit1};
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stage              <= ST_FIRST;
      mirrored_order     <= 1'b0;
      carrier_index      <= '0;
      table_index        <= '0;
      symbol_length      <= '0;
      position_in_symbol <= '0;
      candidate_mask     <= 4'hF;
      sync_symbols_seen  <= '0;
    end else if (step) begin
      stage              <= stage_next;
      mirrored_order     <= mirrored_order_next;
      carrier_index      <= carrier_index_next;
      table_index        <= table_index_next;
      symbol_length      <= symbol_length_next;
      position_in_symbol <= position_in_symbol_next;
      candidate_mask     <= candidate_mask_next;
      sync_symbols_seen  <= sync_symbols_seen_next;
    end
  end

endmodule

FILE: rtl/qrmd_outq.sv
// four-entry result queue taking up to two items per cycle and giving one while the output is not stalled
module qrmd_outq
  import qrmd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  room,
  output logic  out_valid,
  input  logic  out_stall,
  output res_t  head
);

  res_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = entries[rd_ptr];
  // space for the two results one item can produce
  assign room      = (count <= QCNT_W'(QDEPTH - 2));

  // entry storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      entries[wr_ptr] <= push.res0;
    end
    if (push.cnt == 2'd2) begin
      entries[wr_ptr + 1'b1] <= push.res1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.cnt);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count + QCNT_W'(push.cnt) - QCNT_W'(pop);
    end
  end

endmodule

FILE: rtl/qpsk_reference_match_demodulator_unit.sv
// top level of the reference-match qpsk demodulator
//
// Usage:
//   Input channel (in_valid / in_stall) carries one signed 32-bit sample per
//   item plus the last flag marking the end of a stream. Output channel
//   (out_valid / out_stall) carries result items: decoded dibit, stream end,
//   or error with its code. The tolerance register is written through
//   cfg_valid / cfg_ready (ready always high); the user must write it only
//   while the block is idle, which the block itself does not enforce. An
//   accepted item is held in the input register, decoded by the single
//   decode step and its results written into the four-entry result queue,
//   whose head drives the output. Throughput: one item per cycle while the
//   queue has room; an item giving two results (last sample) hands them out
//   one at a time. The decode step runs only while the queue has room for
//   two results, so a stalled output fills the queue and then stalls the
//   input. Reset clears the decode state, the queue and tolerance; a last
//   item returns the decode state to start but keeps tolerance.
module qpsk_reference_match_demodulator_unit
  import qrmd_pkg::*;
#(
  parameter int CARRIER_PERIOD = 18,
  parameter int MAX_SYMBOL_LEN = 4096,
  parameter int SYNC_SYMBOLS   = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [TOL_W-1:0]    tolerance,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          kind,
  output logic [1:0]          dibit,
  output logic [2:0]          error_code
);

  logic [TOL_W-1:0]       tolerance_limit;
  logic [SAMPLE_W-1:0]    sample_hold;
  logic                   last_hold;
  logic                   in_full;
  logic                   step;
  logic                   room;
  logic [3:0]             raw_match;
  logic [TABLE_IDX_W-1:0] table_index;
  push_t                  push;
  res_t                   head;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance_limit <= '0;
    end else if (cfg_valid && cfg_ready) begin
      tolerance_limit <= tolerance;
    end
  end

  // input register
  assign step     = in_full && room;
  assign in_stall = in_full && !step;
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      sample_hold <= sample;
      last_hold   <= last;
    end
  end

  // carrier compare
  qrmd_match u_match (
    .sample      (sample_hold),
    .table_index (table_index),
    .tolerance   (tolerance_limit),
    .raw_match   (raw_match)
  );

  // decode state
  qrmd_fsm #(
    .CARRIER_PERIOD (CARRIER_PERIOD),
    .MAX_SYMBOL_LEN (MAX_SYMBOL_LEN),
    .SYNC_SYMBOLS   (SYNC_SYMBOLS)
  ) u_fsm (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .last        (last_hold),
    .raw_match   (raw_match),
    .table_index (table_index),
    .push        (push)
  );

  // result queue
  qrmd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign kind       = head.kind;
  assign dibit      = head.dibit;
  assign error_code = head.code;

  // a result only appears after a decode step
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(step))
    else $error("result appeared without a decode step");

  // non-dibit results carry no dibit
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind != KIND_DIBIT)) |-> (dibit == 2'd0))
    else $error("dibit set on a non-dibit result");

  // only error results carry an error code
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind != KIND_ERROR)) |-> (error_code == ERR_NONE))
    else $error("error code set on a non-error result");

  // decode never runs without queue space
  assert property (@(posedge clk) disable iff (rst) step |-> (in_full && room))
    else $error("decode step without room");

endmodule

FILE: test/qrmd_result_checker.sv
// result checker for the qpsk reference-match demodulator: predicts and compares results
module qrmd_result_checker
  import qrmd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [TOL_W-1:0]    tolerance,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                last,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [1:0]          kind,
  input  logic [1:0]          dibit,
  input  logic [2:0]          error_code,
  output int                  errors,
  output int                  pending,
  output int                  checked
);

  localparam int PERIOD      = 18;
  localparam int LONGEST_RUN = 4096;
  localparam int SYNC_LEN    = 4;

  // peak amplitude times sine of 5, 15, ..., 85 degrees
  localparam longint PEAK_SINE [9] = '{
    185703301, 551467404, 900475448, 1222123002, 1506636966,
    1745372529, 1931075831, 2058104370, 2122598450
  };

  // predicted decoder state
  logic [TOL_W-1:0] tol_limit;
  logic             mirrored;
  stage_t           stage;
  int               carrier_pos;
  int               sym_len;
  int               sym_pos;
  logic [3:0]       alive;
  int               sync_count;

  res_t expected_results[$];
  res_t want;

  // reference carrier value of one candidate at one table position
  function automatic longint carrier_level(logic mirr, int cand, int pos);
    int     phase;
    int     deg;
    int     r;
    longint mag;
    case (cand)
      0: phase = 135;
      1: phase = 45;
      2: phase = 225;
      default: phase = 315;
    endcase
    if (mirr) begin
      phase = 360 - phase;
    end
    deg = (20 * pos + phase) % 360;
    r = deg % 180;
    mag = PEAK_SINE[(r < 90) ? r / 10 : (179 - r) / 10];
    return (deg >= 180) ? -mag : mag;
  endfunction

  function automatic logic hits(logic mirr, int cand, int pos, longint s);
    longint diff;
    diff = carrier_level(mirr, cand, pos) - s;
    if (diff < 0) begin
      diff = -diff;
    end
    return diff <= longint'(tol_limit);
  endfunction

  function automatic res_t make_result(kind_t k, logic [1:0] d, err_t c);
    res_t r;
    r.kind  = k;
    r.dibit = d;
    r.code  = c;
    return r;
  endfunction

  // append one predicted result at the tail
  task automatic add_expected(res_t r);
    expected_results = {expected_results, r};
  endtask

  task automatic flag_error(err_t c);
    add_expected(make_result(KIND_ERROR, 2'd0, c));
    stage = ST_FAILED;
  endtask

  task automatic clear_stream();
    mirrored    = 1'b0;
    stage       = ST_FIRST;
    carrier_pos = 0;
    sym_len     = 0;
    sym_pos     = 0;
    alive       = 4'hF;
    sync_count  = 0;
  endtask

  // one sample of a sync or data symbol
  task automatic symbol_step(longint s, int pos);
    int d;
    for (int c = 0; c < 4; c++) begin
      if (!hits(mirrored, c, pos, s)) begin
        alive[c] = 1'b0;
      end
    end
    if (sym_pos + 1 < sym_len) begin
      sym_pos++;
    end else begin
      sym_pos = 0;
      if (alive == 4'h0) begin
        flag_error(ERR_NO_PHASE);
      end else begin
        d = 0;
        while (!alive[d]) begin
          d++;
        end
        alive = 4'hF;
        if (stage == ST_SYNC) begin
          // sync pattern alternates 0 and 3
          if (d != ((sync_count % 2 == 1) ? 3 : 0)) begin
            flag_error(ERR_SYNC);
          end else begin
            sync_count++;
            if (sync_count >= SYNC_LEN) begin
              stage = ST_DATA;
            end
          end
        end else begin
          add_expected(make_result(KIND_DIBIT, 2'(d), ERR_NONE));
        end
      end
    end
  endtask

  // predict the results of one accepted item
  task automatic decode_sample(logic [SAMPLE_W-1:0] raw, logic is_last);
    longint s;
    int     pos;
    s = longint'($signed(raw));
    pos = carrier_pos;
    case (stage)
      ST_FIRST: begin
        // first sample picks the phase order
        if (hits(1'b0, 0, pos, s)) begin
          mirrored = 1'b0;
          stage = ST_RUN;
          sym_len = 1;
        end else if (hits(1'b1, 0, pos, s)) begin
          mirrored = 1'b1;
          stage = ST_RUN;
          sym_len = 1;
        end else begin
          mirrored = 1'b0;
          flag_error(ERR_BAD_START);
        end
      end
      ST_RUN: begin
        // first symbol run measures the symbol length
        if (hits(mirrored, 0, pos, s)) begin
          if (sym_len >= LONGEST_RUN) begin
            flag_error(ERR_LENGTH);
          end else begin
            sym_len++;
          end
        end else begin
          sync_count = 1;
          stage = (SYNC_LEN <= 1) ? ST_DATA : ST_SYNC;
          sym_pos = 0;
          alive = 4'hF;
          symbol_step(s, pos);
        end
      end
      ST_SYNC, ST_DATA: begin
        symbol_step(s, pos);
      end
      default: begin
      end
    endcase
    carrier_pos = (pos + 1) % PERIOD;
    // stream end: complete sync and no partial symbol ends well
    if (is_last) begin
      if (stage != ST_FAILED) begin
        if (stage == ST_DATA && sym_pos == 0) begin
          add_expected(make_result(KIND_END, 2'd0, ERR_NONE));
        end else begin
          add_expected(make_result(KIND_ERROR, 2'd0, ERR_LENGTH));
        end
      end
      clear_stream();
    end
  endtask

  // watch the three channels
  always @(posedge clk) begin
    if (rst) begin
      tol_limit = '0;
      clear_stream();
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        tol_limit = tolerance;
      end
      if (out_valid && !out_stall) begin
        checked++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result kind %0d dibit %0d code %0d", $time,
                   kind, dibit, error_code);
        end else begin
          want = expected_results.pop_front();
          if (want.kind !== kind || want.dibit !== dibit || want.code !== error_code) begin
            errors++;
            $display("%0t: result mismatch, expected kind %0d dibit %0d code %0d,",
                     $time, want.kind, want.dibit, want.code);
            $display("%0t:   got kind %0d dibit %0d code %0d",
                     $time, kind, dibit, error_code);
          end
        end
      end
      if (in_valid && !in_stall) begin
        decode_sample(sample, last);
      end
    end
    pending = expected_results.size();
  end

endmodule

FILE: test/qpsk_reference_match_demodulator_unit_test.sv
// testbench top for the qpsk reference-match demodulator: stimulus, output pacing and verdict
module qpsk_reference_match_demodulator_unit_test;
  import qrmd_pkg::*;

  localparam int               RANDOM_ITEMS  = 1650;
  localparam int               HOLD_CYCLES   = 300;
  localparam int               SETTLE_CYCLES = 8;
  localparam logic [TOL_W-1:0] TOL_MAX       = 17'd65536;

  typedef enum int {
    FLAW_NONE,
    FLAW_SYNC,
    FLAW_NOISE,
    FLAW_SHORT,
    FLAW_EARLY,
    FLAW_JUNK
  } flaw_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [TOL_W-1:0]    tolerance = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] sample = '0;
  logic                last = 1'b0;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          kind;
  logic [1:0]          dibit;
  logic [2:0]          error_code;

  int               fail_count;
  int               pending;
  int               checked;
  int               tx_mode = 0;
  int               rx_mode = 0;
  int               hold_req = 0;
  int               hold_done = 0;
  int               wave_pos = 0;
  int               items_sent = 0;
  int               streams_sent = 0;
  logic [TOL_W-1:0] tol_now = '0;

  always #5 clk = ~clk;

  qpsk_reference_match_demodulator_unit #(
    .CARRIER_PERIOD(18),
    .MAX_SYMBOL_LEN(4096),
    .SYNC_SYMBOLS(4)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .tolerance(tolerance),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample(sample),
    .last(last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .dibit(dibit),
    .error_code(error_code)
  );

  qrmd_result_checker chk (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .tolerance(tolerance),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample(sample),
    .last(last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .dibit(dibit),
    .error_code(error_code),
    .errors(fail_count),
    .pending(pending),
    .checked(checked)
  );

  // idle cycles before one item: none, full range, or mostly none
  function automatic int idle_draw(int mode);
    int n;
    case (mode)
      0: n = 0;
      1: n = $urandom_range(0, 16);
      default: n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    endcase
    return n;
  endfunction

  // carrier level for building samples, by half-period symmetry
  function automatic longint wave_level(logic mirr, int cand, int pos);
    int     ph;
    int     a;
    int     q;
    longint m;
    case (cand)
      0: ph = mirr ? 225 : 135;
      1: ph = mirr ? 315 : 45;
      2: ph = mirr ? 135 : 225;
      default: ph = mirr ? 45 : 315;
    endcase
    a = (20 * pos + ph) % 360;
    q = (a % 180) / 10;
    case ((q < 9) ? q : 17 - q)
      0: m = 185703301;
      1: m = 551467404;
      2: m = 900475448;
      3: m = 1222123002;
      4: m = 1506636966;
      5: m = 1745372529;
      6: m = 1931075831;
      7: m = 2058104370;
      default: m = 2122598450;
    endcase
    return (a >= 180) ? -m : m;
  endfunction

  // a sample inside the tolerance of one candidate, often right at the edge
  function automatic logic [SAMPLE_W-1:0] near_level(logic mirr, int cand, int pos);
    longint lvl;
    int     off;
    lvl = wave_level(mirr, cand, pos);
    if ($urandom_range(0, 3) == 0) begin
      off = ($urandom_range(0, 1) == 1) ? int'(tol_now) : -int'(tol_now);
    end else begin
      off = int'($urandom_range(0, 2 * int'(tol_now))) - int'(tol_now);
    end
    return SAMPLE_W'(lvl + off);
  endfunction

  // offer one item and hold it until accepted
  task automatic push_sample(logic [SAMPLE_W-1:0] s, logic l);
    int gap;
    gap = idle_draw(tx_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    last <= l;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
    wave_pos = l ? 0 : (wave_pos + 1) % CARRIER_TABLE_LEN;
    if (l) begin
      streams_sent++;
    end
  endtask

  // one symbol of a candidate; last_at raises last and cuts it, junk_at spoils one sample
  task automatic send_symbol(logic mirr, int cand, int len, int last_at, int junk_at);
    logic [SAMPLE_W-1:0] s;
    longint              miss;
    for (int i = 0; i < len; i++) begin
      if (i == junk_at) begin
        miss = longint'(tol_now) + 1;
        if ($urandom_range(0, 1) == 1) begin
          s = $urandom;
        end else begin
          s = SAMPLE_W'(wave_level(mirr, cand, wave_pos) +
                        (($urandom_range(0, 1) == 1) ? miss : -miss));
        end
      end else begin
        s = near_level(mirr, cand, wave_pos);
      end
      push_sample(s, i == last_at);
      if (i == last_at) begin
        break;
      end
    end
  endtask

  // run symbol, sync pattern and data symbols, optionally broken
  task automatic send_stream(logic mirr, int len, int n_data, flaw_t flaw);
    int syms[$];
    int cut_sym;
    int cut_at;
    int junk_sym;
    int junk_at;
    int k;
    if (flaw == FLAW_JUNK) begin
      k = $urandom_range(1, 12);
      for (int i = 0; i < k; i++) begin
        push_sample($urandom, i == k - 1);
      end
    end else begin
      syms = '{0, 3, 0, 3};
      for (int i = 0; i < n_data; i++) begin
        syms = {syms, int'($urandom_range(0, 3))};
      end
      cut_sym = syms.size() - 1;
      cut_at = len - 1;
      junk_sym = -1;
      junk_at = -1;
      case (flaw)
        FLAW_SYNC: begin
          k = $urandom_range(1, 3);
          syms[k] = (syms[k] + int'($urandom_range(1, 3))) % 4;
        end
        FLAW_NOISE: begin
          junk_sym = $urandom_range(4, syms.size() - 1);
          junk_at = $urandom_range(0, len - 1);
        end
        FLAW_SHORT: cut_at = (len > 1) ? $urandom_range(0, len - 2) : 0;
        FLAW_EARLY: begin
          cut_sym = $urandom_range(0, 3);
          cut_at = $urandom_range(0, len - 1);
        end
        default: begin
        end
      endcase
      for (int i = 0; i <= cut_sym; i++) begin
        send_symbol(mirr, syms[i], len, (i == cut_sym) ? cut_at : -1,
                    (i == junk_sym) ? junk_at : -1);
      end
    end
  endtask

  // tolerance register write, only while the block is idle
  task automatic set_tolerance(logic [TOL_W-1:0] v);
    tolerance <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    tol_now = v;
  endtask

  // stop offering until every expected result is out, then let the pipeline settle
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // output side: random stalls per item, long holds on request
  initial begin
    int w;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_done != hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done++;
      end else begin
        w = idle_draw(rx_mode);
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // run limit
  initial begin
    #20000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int               normal_pat[8];
    int               mirror_pat[8];
    int               phase;
    int               base;
    int               r;
    int               len;
    flaw_t            flaw;
    logic [TOL_W-1:0] v;

    normal_pat = '{0, 3, 0, 3, 0, 1, 2, 3};
    mirror_pat = '{0, 3, 0, 3, 3, 2, 1, 0};
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: sample extremes, a start without a run, every dibit in both orders
    push_sample(32'h7FFF_FFFF, 1'b1);
    push_sample(32'h8000_0000, 1'b1);
    push_sample(near_level(1'b0, 0, 0), 1'b1);
    push_sample(32'h0000_0000, 1'b0);
    push_sample(32'hFFFF_FFFF, 1'b1);
    for (int i = 0; i < 8; i++) begin
      send_symbol(1'b0, normal_pat[i], 1, (i == 7) ? 0 : -1, -1);
    end
    for (int i = 0; i < 8; i++) begin
      send_symbol(1'b1, mirror_pat[i], 2, (i == 7) ? 1 : -1, -1);
    end
    // sync mismatch, no phase, cut symbol, end inside the sync
    send_stream(1'b0, 1, 2, FLAW_SYNC);
    send_stream(1'b1, 1, 3, FLAW_NOISE);
    send_stream(1'b0, 2, 3, FLAW_SHORT);
    send_stream(1'b1, 2, 1, FLAW_EARLY);

    // random phases, each with its own tolerance and pacing
    phase = 0;
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      wait_results_drained();
      case (phase)
        0: v = '0;
        1: v = 17'd1;
        2: v = TOL_MAX;
        default: begin
          case ($urandom_range(0, 3))
            0: v = '0;
            1: v = TOL_MAX;
            2: v = TOL_W'($urandom_range(1, 64));
            default: v = TOL_W'($urandom_range(65, 65535));
          endcase
        end
      endcase
      set_tolerance(v);
      tx_mode = $urandom_range(0, 2);
      rx_mode = $urandom_range(0, 2);
      // back-pressure: output held while items keep coming
      if (phase == 1 || $urandom_range(0, 7) == 0) begin
        tx_mode = 0;
        hold_req++;
      end
      repeat (8) begin
        r = $urandom_range(0, 9);
        if (r <= 5) begin
          flaw = FLAW_NONE;
        end else if (r == 6) begin
          flaw = FLAW_SYNC;
        end else if (r == 7) begin
          flaw = FLAW_NOISE;
        end else if (r == 8) begin
          flaw = ($urandom_range(0, 1) == 1) ? FLAW_SHORT : FLAW_EARLY;
        end else begin
          flaw = FLAW_JUNK;
        end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        send_stream(1'($urandom_range(0, 1)), len, $urandom_range(1, 12), flaw);
      end
      phase++;
    end

    wait_results_drained();
    $display("run covered %0d samples in %0d streams over %0d tolerance phases,",
             items_sent, streams_sent, phase);
    $display("%0d results checked, both phase orders, all error codes, %0d long output holds",
             checked, hold_done);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
